// ===== rtl/round_robin_task_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin task scheduler
// Shared forms for the concurrent checks on the scheduler ports.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RRTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes shared by the round-robin task scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrts_pkg;

   // Task slot states as held in the slot memory.
   typedef enum logic [2:0] {
      ST_STOPPED   = 3'd0,
      ST_READY     = 3'd1,
      ST_RUNNING   = 3'd2,
      ST_BLOCKED   = 3'd3,
      ST_SUSPENDED = 3'd4
   } slot_state_type;

   // Request kinds carried on the request tuser.
   typedef enum logic [2:0] {
      REQ_START   = 3'd0,
      REQ_SWITCH  = 3'd1,
      REQ_DELAY   = 3'd2,
      REQ_SUSPEND = 3'd3,
      REQ_RESUME  = 3'd4
   } req_kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_ERROR    = 2'd1,
      STAT_NO_READY = 2'd2
   } status_type;

   // Word index of the task count register on the CSR port.
   localparam logic CSR_TASK_COUNT = 1'b0;

   // What the slot update applies to the slot word just read.
   typedef struct packed {
      logic countdown;
      logic demote;
      logic pick;
   } slot_op_type;

   // One response word, status in the lowest bits.
   typedef struct packed {
      logic [31:0] switch_total;
      logic        switched;
      logic [3:0]  running_task;
      status_type  status;
   } result_type;

endpackage

// ===== rtl/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler over a ring of task slots held in one memory.
//
//   Port group  Direction  Word
//   req_        in         tuser: request kind; tdata: task id, ticks
//   rsp_        out        tdata: status, running task, switched, switch total
//   csr_        in/out     APB-style access to the task count register
//
// A switch walks the ring with a read and a write per slot; a delay first
// writes the current slot, a suspend or resume first reads and writes its
// target slot and walks only when that is the current slot, and a current
// slot outside the ring is read and written once more after the walk. Start
// rewrites every slot; a rejected request is answered without a walk.
// Reset marks every slot stopped through per-slot valid bits, no clearing pass.
// One request is in work at a time; a finished response waits in the output
// register while the next request is taken, and a second finished response
// holds the request side closed until the output register drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_task_scheduler #(
   parameter int MAX_TASKS  = 16,
   parameter int DELAY_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [3:0] task_id, [19:4] ticks, [23:20] zero
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] status, [5:2] running_task,
                                    // [6] switched, [38:7] switch_total, [39] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   import rrts_pkg::*;

   localparam int SW = $clog2(MAX_TASKS);
   localparam int WW = DELAY_BITS + 3;

   logic [4:0]   task_count_ff, task_count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   result_type   rsp_data_ff, rsp_data_in;

   logic         res_valid;
   logic         res_ready;
   result_type   res;
   logic         mem_wr_en;
   logic [SW-1:0] mem_wr_addr;
   logic [WW-1:0] mem_wr_data;
   logic         mem_rd_en;
   logic [SW-1:0] mem_rd_addr;
   logic [WW-1:0] mem_rd_data;
   logic         csr_write;

   // Configuration register: written in the access phase of a write.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      task_count_in = task_count_ff;
      if (csr_write && (csr_paddr[2] == CSR_TASK_COUNT)) begin
         task_count_in = csr_pwdata[4:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_TASK_COUNT) ? {27'd0, task_count_ff} : 32'd0;

   // Output register: takes a response whenever it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= 5'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         task_count_ff <= task_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   rrts_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_TASKS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   rrts_seq #(
      .MAX_TASKS  (MAX_TASKS),
      .DELAY_BITS (DELAY_BITS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_type    (req_tuser),
      .task_id     (req_tdata[3:0]),
      .ticks       (req_tdata[19:4]),
      .task_count  (task_count_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

endmodule

// ===== rtl/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rrts_slot_alu.sv =====
// ----------------------------------------------------------------------------
// rrts_slot_alu
// Update of one task slot: delay countdown, demotion and pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_slot_alu #(
   parameter int DELAY_BITS = 16
) (
   input  rrts_pkg::slot_op_type    op,
   input  rrts_pkg::slot_state_type in_state,
   input  logic [DELAY_BITS-1:0]    in_delay,
   output rrts_pkg::slot_state_type out_state,
   output logic [DELAY_BITS-1:0]    out_delay,
   output logic                     picked
);

   import rrts_pkg::*;

   always_comb begin
      out_state = in_state;
      out_delay = in_delay;
      picked    = 1'b0;

      // A blocked slot counts down; reaching zero wakes it.
      if (op.countdown && (in_state == ST_BLOCKED) && (in_delay != '0)) begin
         out_delay = in_delay - DELAY_BITS'(1);
         if (out_delay == '0) begin
            out_state = ST_READY;
         end
      end

      // The running slot steps back to ready.
      if (op.demote && (out_state == ST_RUNNING)) begin
         out_state = ST_READY;
      end

      // The first ready slot on the walk becomes the running one.
      if (op.pick && (out_state == ST_READY)) begin
         out_state = ST_RUNNING;
         picked    = 1'b1;
      end
   end

endmodule

// ===== rtl/rrts_seq.sv =====
// ----------------------------------------------------------------------------
// rrts_seq
// Request sequencer: walks the slot memory with read-modify-write steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrts_seq #(
   parameter int MAX_TASKS  = 16,
   parameter int DELAY_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [2:0]                         req_type,
   input  logic [3:0]                         task_id,
   input  logic [15:0]                        ticks,
   input  logic [4:0]                         task_count,
   output logic                               res_valid,
   input  logic                               res_ready,
   output rrts_pkg::result_type               res,
   output logic                               mem_wr_en,
   output logic [$clog2(MAX_TASKS)-1:0]       mem_wr_addr,
   output logic [DELAY_BITS+2:0]              mem_wr_data,
   output logic                               mem_rd_en,
   output logic [$clog2(MAX_TASKS)-1:0]       mem_rd_addr,
   input  logic [DELAY_BITS+2:0]              mem_rd_data
);

   import rrts_pkg::*;

   localparam int SW = $clog2(MAX_TASKS);
   localparam int NW = $clog2(MAX_TASKS + 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SWEEP,
      S_PRE_RD,
      S_PRE_WR,
      S_WALK_RD,
      S_WALK_WR,
      S_EXTRA_RD,
      S_EXTRA_WR,
      S_COMMIT,
      S_DONE
   } seq_state_type;

   seq_state_type         state_ff, state_in;
   req_kind_type          kind_ff, kind_in;
   logic [SW-1:0]         addr_ff, addr_in;
   logic [NW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]         cur_ff, cur_in;
   logic [31:0]           count_ff, count_in;
   logic                  found_ff, found_in;
   logic [SW-1:0]         pick_ff, pick_in;
   logic [DELAY_BITS-1:0] ticks_ff, ticks_in;
   status_type            status_ff, status_in;
   logic                  switched_ff, switched_in;
   logic [MAX_TASKS-1:0]  valid_ff, valid_in;
   logic                  rvalid_ff, rvalid_in;

   logic [NW-1:0]         ring_n;
   slot_state_type        rd_state;
   logic [DELAY_BITS-1:0] rd_delay;
   slot_op_type           op;
   slot_state_type        alu_state;
   logic [DELAY_BITS-1:0] alu_delay;
   logic                  alu_picked;
   logic                  target_ok;
   slot_state_type        sweep_state;

   // Next slot in ring order; a slot outside the ring wraps to slot zero.
   function automatic logic [SW-1:0] ring_next(input logic [SW-1:0] idx,
                                                input logic [NW-1:0] n);
      logic [SW-1:0] nxt;
      nxt = idx + SW'(1);
      if (32'(idx) + 32'd1 >= 32'(n)) begin
         nxt = '0;
      end
      return nxt;
   endfunction

   // Effective ring size: zero counts as one, large values clamp.
   always_comb begin
      if (task_count == 5'd0) begin
         ring_n = NW'(1);
      end else if (32'(task_count) > MAX_TASKS) begin
         ring_n = NW'(MAX_TASKS);
      end else begin
         ring_n = NW'(task_count);
      end
   end

   // A slot never written reads as stopped with no delay.
   assign rd_state = rvalid_ff ? slot_state_type'(mem_rd_data[2:0]) : ST_STOPPED;
   assign rd_delay = rvalid_ff ? mem_rd_data[DELAY_BITS+2:3] : '0;

   rrts_slot_alu #(
      .DELAY_BITS (DELAY_BITS)
   ) u_slot_alu (
      .op        (op),
      .in_state  (rd_state),
      .in_delay  (rd_delay),
      .out_state (alu_state),
      .out_delay (alu_delay),
      .picked    (alu_picked)
   );

   // Suspend needs a ready or running target, resume a suspended one.
   always_comb begin
      if (kind_ff == REQ_SUSPEND) begin
         target_ok = (rd_state == ST_READY) || (rd_state == ST_RUNNING);
      end else begin
         target_ok = (rd_state == ST_SUSPENDED);
      end
   end

   // Start pattern: ring slots ready, the last one running, the rest stopped.
   always_comb begin
      if (32'(addr_ff) + 32'd1 == 32'(ring_n)) begin
         sweep_state = ST_RUNNING;
      end else if (32'(addr_ff) < 32'(ring_n)) begin
         sweep_state = ST_READY;
      end else begin
         sweep_state = ST_STOPPED;
      end
   end

   // Sequencer next-state and memory control.
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      addr_in     = addr_ff;
      cnt_in      = cnt_ff;
      cur_in      = cur_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      ticks_in    = ticks_ff;
      status_in   = status_ff;
      switched_in = switched_ff;
      valid_in    = valid_ff;
      rvalid_in   = rvalid_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = addr_ff;
      op          = '0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in     = req_kind_type'(req_type);
               ticks_in    = DELAY_BITS'(32'(ticks));
               status_in   = STAT_OK;
               switched_in = 1'b0;
               found_in    = 1'b0;
               cnt_in      = '0;
               case (req_kind_type'(req_type))
                  REQ_START: begin
                     addr_in  = '0;
                     state_in = S_SWEEP;
                  end
                  REQ_SWITCH: begin
                     addr_in  = ring_next(cur_ff, ring_n);
                     state_in = S_WALK_RD;
                  end
                  REQ_DELAY: begin
                     addr_in  = cur_ff;
                     state_in = S_PRE_WR;
                  end
                  REQ_SUSPEND, REQ_RESUME: begin
                     if (32'(task_id) >= 32'(ring_n)) begin
                        status_in = STAT_ERROR;
                        state_in  = S_DONE;
                     end else begin
                        addr_in  = SW'(32'(task_id));
                        state_in = S_PRE_RD;
                     end
                  end
                  default: begin
                     status_in = STAT_ERROR;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end

         // Rewrite every slot, one per cycle.
         S_SWEEP: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = {{DELAY_BITS{1'b0}}, sweep_state};
            if (32'(addr_ff) == MAX_TASKS - 1) begin
               cur_in   = SW'(32'(ring_n) - 32'd1);
               state_in = S_DONE;
            end else begin
               addr_in = addr_ff + SW'(1);
            end
         end

         S_PRE_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_PRE_WR;
         end

         // Change the target slot before any switch.
         S_PRE_WR: begin
            if (kind_ff == REQ_DELAY) begin
               mem_wr_en   = 1'b1;
               mem_wr_data = {ticks_ff, ST_BLOCKED};
               addr_in     = ring_next(cur_ff, ring_n);
               state_in    = S_WALK_RD;
            end else if (!target_ok) begin
               status_in = STAT_ERROR;
               state_in  = S_DONE;
            end else begin
               mem_wr_en = 1'b1;
               if (kind_ff == REQ_SUSPEND) begin
                  mem_wr_data = {rd_delay, ST_SUSPENDED};
               end else begin
                  mem_wr_data = {rd_delay, ST_READY};
               end
               if (addr_ff == cur_ff) begin
                  addr_in  = ring_next(cur_ff, ring_n);
                  state_in = S_WALK_RD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end

         S_WALK_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_WALK_WR;
         end

         // Count down, demote and pick on one slot, then move on round the ring.
         S_WALK_WR: begin
            op.countdown = 1'b1;
            op.demote    = (addr_ff == cur_ff);
            op.pick      = !found_ff;
            mem_wr_en    = 1'b1;
            mem_wr_data  = {alu_delay, alu_state};
            if (alu_picked) begin
               found_in = 1'b1;
               pick_in  = addr_ff;
            end
            if (32'(cnt_ff) + 32'd1 >= 32'(ring_n)) begin
               if (32'(cur_ff) >= 32'(ring_n)) begin
                  addr_in  = cur_ff;
                  state_in = S_EXTRA_RD;
               end else begin
                  state_in = S_COMMIT;
               end
            end else begin
               cnt_in   = cnt_ff + NW'(1);
               addr_in  = ring_next(addr_ff, ring_n);
               state_in = S_WALK_RD;
            end
         end

         // The current slot lies outside the ring: demote it on its own.
         S_EXTRA_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_EXTRA_WR;
         end

         S_EXTRA_WR: begin
            op.demote   = 1'b1;
            mem_wr_en   = 1'b1;
            mem_wr_data = {alu_delay, alu_state};
            state_in    = S_COMMIT;
         end

         S_COMMIT: begin
            if (found_ff) begin
               cur_in      = pick_ff;
               count_in    = count_ff + 32'd1;
               switched_in = 1'b1;
               status_in   = STAT_OK;
            end else begin
               status_in = STAT_NO_READY;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (mem_wr_en) begin
         valid_in[mem_wr_addr] = 1'b1;
      end
      if (mem_rd_en) begin
         rvalid_in = valid_ff[mem_rd_addr];
      end
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff   <= '0;
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      cnt_ff      <= cnt_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      ticks_ff    <= ticks_in;
      status_ff   <= status_in;
      switched_ff <= switched_in;
      rvalid_ff   <= rvalid_in;
   end

   assign res.status       = status_ff;
   assign res.running_task = 4'(32'(cur_ff));
   assign res.switched     = switched_ff;
   assign res.switch_total = count_ff;

endmodule

// ===== rtl/rrts_checker.sv =====
// ----------------------------------------------------------------------------
// rrts_checker
// Port-level checks on the round-robin task scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "round_robin_task_scheduler_macros.svh"

module rrts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   import rrts_pkg::*;

   // A stalled response word holds its value.
   `RRTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // Only one request is in work: after an accept the request side closes.
   `RRTS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while another is in work")

   // A response that reports a switch carries an ok status.
   `RRTS_ASSERT_NOW(a_switch_ok, clock, reset, rsp_tvalid && rsp_tdata[6], rsp_tdata[1:0] == STAT_OK, "switch reported with a failing status")

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
